[rtl/sra_pkg.sv]
// ----------------------------------------------------------------------------
// SPI register access package
// Shared types, frame bytes and helpers for the SPI register access master.
// ----------------------------------------------------------------------------
package sra_pkg;

  typedef enum logic [2:0] {
    ACT_WRITE   = 3'd0,
    ACT_READ    = 3'd1,
    ACT_EXTRACT = 3'd2,
    ACT_MODIFY  = 3'd3,
    ACT_RX_BYTE = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_EXTRACT = 2'd2,
    KIND_MODIFY  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_FRAME = 4'b0010,
    PH_POLL  = 4'b0100,
    PH_DATA  = 4'b1000
  } phase_t;

  typedef enum logic [0:0] {
    REG_WRITE_ATTEMPTS = 1'b0,
    REG_READ_ATTEMPTS  = 1'b1
  } reg_idx_t;

  localparam logic [7:0] BYTE_SYNC   = 8'h00;
  localparam logic [7:0] WR_OPCODE   = 8'h09;
  localparam logic [7:0] WR_LENGTH   = 8'h01;
  localparam logic [7:0] RD_OPCODE   = 8'h0A;
  localparam logic [7:0] RD_LENGTH   = 8'h05;
  localparam logic [7:0] POLL_BYTE   = 8'hFF;
  localparam logic [7:0] ACK_BYTE    = 8'h00;
  localparam logic [7:0] TIMEOUT_BYTE = 8'h11;

  localparam logic [3:0] WR_FRAME_LEN = 4'd12;
  localparam logic [3:0] RD_FRAME_LEN = 4'd7;
  localparam logic [3:0] DATA_BYTES   = 4'd4;

  localparam logic [4:0] WR_ATTEMPTS_RST = 5'd5;
  localparam logic [4:0] RD_ATTEMPTS_RST = 5'd20;
  localparam logic [4:0] RETRY_MAX       = 5'd31;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        select_active;
    logic        done_res;
    logic        status;
    logic [31:0] read_data;
    logic [4:0]  attempts_used;
    logic        last;
  } res_t;

  function automatic logic [4:0] limit_of(logic [4:0] v);
    return (v == 5'd0) ? 5'd1 : v;
  endfunction

endpackage

[rtl/sra_if.sv]
// ----------------------------------------------------------------------------
// SPI register access channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface sra_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] address;
  logic [31:0] write_data;
  logic [31:0] field_mask;
  logic [4:0]  field_shift;
  logic [7:0]  rx_byte;

  modport source (
    output valid, action, address, write_data, field_mask, field_shift, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, action, address, write_data, field_mask, field_shift, rx_byte,
    output ready
  );
endinterface

interface sra_out_if;
  logic        valid;
  logic        ready;
  logic        send_valid;
  logic [7:0]  send_byte;
  logic        select_active;
  logic        done_res;
  logic        status;
  logic [31:0] read_data;
  logic [4:0]  attempts_used;
  logic        last;

  modport source (
    output valid, send_valid, send_byte, select_active, done_res, status,
           read_data, attempts_used, last,
    input  ready
  );
  modport sink (
    input  valid, send_valid, send_byte, select_active, done_res, status,
           read_data, attempts_used, last,
    output ready
  );
endinterface

[rtl/sra_out_queue.sv]
// ----------------------------------------------------------------------------
// SPI register access result queue
// Four-entry queue that takes up to two result words per cycle.
// ----------------------------------------------------------------------------
module sra_out_queue import sra_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  res_t       push0,
  input  res_t       push1,
  output logic       space_ok,
  output logic       head_valid,
  input  logic       head_ready,
  output res_t       head
);

  localparam int Depth = 4;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = AW + 1;

  res_t           mem_r [Depth];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           pop;

  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid & head_ready;
  assign space_ok   = (count_r <= CW'(Depth - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    count_nxt  = count_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + AW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/spi_register_access_master.sv]
// ----------------------------------------------------------------------------
// SPI register access master
// Frames register requests for a byte-wide SPI bridge and steps through
// polling, retries and data capture one received link byte at a time.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      word
//  in_word   sink       valid/ready    request or received link byte
//  out_word  source     valid/ready    next byte, select, completion status
//  apb       slave      psel/penable   attempt limits at 0x0 and 0x4
//
//  One word is taken per cycle; its results are computed in that cycle and
//  land in a four-entry result queue, drained at one word per cycle while
//  out_word.ready is high. A word yields up to two results, so in_word.ready
//  falls while the queue has fewer than two free entries.
//  Synchronous active-low reset clears control state and loads limits 5/20.
// ----------------------------------------------------------------------------
module spi_register_access_master import sra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sra_in_if.sink      in_word,
  sra_out_if.source   out_word
);

  logic [4:0]  wr_att_r, rd_att_r;
  phase_t      phase_r, phase_nxt;
  kind_t       kind_r, kind_nxt;
  logic        wpend_r, wpend_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [4:0]  left_r, left_nxt;
  logic [4:0]  retry_r, retry_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] data_r, data_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [4:0]  shift_r, shift_nxt;
  logic [31:0] rdsh_r, rdsh_nxt;

  logic        accept;
  logic        space_ok;
  logic        writing;
  logic [3:0]  idx_inc;
  logic [7:0]  fbyte;
  logic [1:0]  push_cnt;
  res_t        push0, push1, head;
  logic        head_valid;
  logic        cfg_wr;
  reg_idx_t    cfg_sel;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = reg_idx_t'(paddr[2]);

  always_comb begin
    case (cfg_sel)
      REG_WRITE_ATTEMPTS: prdata = {27'd0, wr_att_r};
      REG_READ_ATTEMPTS:  prdata = {27'd0, rd_att_r};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_att_r <= WR_ATTEMPTS_RST;
      rd_att_r <= RD_ATTEMPTS_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_WRITE_ATTEMPTS: wr_att_r <= pwdata[4:0];
        REG_READ_ATTEMPTS:  rd_att_r <= pwdata[4:0];
        default:            ;
      endcase
    end
  end

  // request engine
  assign in_word.ready = space_ok;
  assign accept        = in_word.valid & space_ok;
  assign writing       = (kind_r == KIND_WRITE) | ((kind_r == KIND_MODIFY) & wpend_r);
  assign idx_inc       = idx_r + 4'd1;

  always_comb begin
    case (idx_inc)
      4'd0:    fbyte = BYTE_SYNC;
      4'd1:    fbyte = writing ? WR_OPCODE : RD_OPCODE;
      4'd2:    fbyte = writing ? WR_LENGTH : RD_LENGTH;
      4'd3:    fbyte = addr_r[31:24];
      4'd4:    fbyte = addr_r[23:16];
      4'd5:    fbyte = addr_r[15:8];
      4'd6:    fbyte = addr_r[7:0];
      4'd7:    fbyte = writing ? data_r[31:24] : BYTE_SYNC;
      4'd8:    fbyte = writing ? data_r[23:16] : BYTE_SYNC;
      4'd9:    fbyte = writing ? data_r[15:8] : BYTE_SYNC;
      4'd10:   fbyte = writing ? data_r[7:0] : BYTE_SYNC;
      default: fbyte = BYTE_SYNC;
    endcase
  end

  always_comb begin
    res_t send_w, start_w, rel_w, fin_w;
    logic [4:0]  left_dec;
    logic [4:0]  retry_inc;
    logic [31:0] rx_sh;

    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    wpend_nxt = wpend_r;
    idx_nxt   = idx_r;
    left_nxt  = left_r;
    retry_nxt = retry_r;
    addr_nxt  = addr_r;
    data_nxt  = data_r;
    mask_nxt  = mask_r;
    shift_nxt = shift_r;
    rdsh_nxt  = rdsh_r;
    push_cnt  = 2'd0;

    send_w = '{send_valid: 1'b1, send_byte: POLL_BYTE, select_active: 1'b1,
               done_res: 1'b0, status: 1'b0, read_data: 32'd0,
               attempts_used: 5'd0, last: 1'b1};
    start_w           = send_w;
    start_w.send_byte = BYTE_SYNC;
    rel_w             = '0;
    fin_w             = '0;
    fin_w.done_res    = 1'b1;
    fin_w.last        = 1'b1;
    fin_w.attempts_used = retry_r;
    push0     = send_w;
    push1     = start_w;

    left_dec  = left_r - 5'd1;
    retry_inc = (retry_r != RETRY_MAX) ? retry_r + 5'd1 : retry_r;
    rx_sh     = {rdsh_r[23:0], in_word.rx_byte};

    if (accept) begin
      if (in_word.action <= ACT_MODIFY) begin
        if (phase_r == PH_IDLE) begin
          kind_nxt  = kind_t'(in_word.action[1:0]);
          wpend_nxt = 1'b0;
          addr_nxt  = in_word.address;
          data_nxt  = in_word.write_data;
          mask_nxt  = in_word.field_mask;
          shift_nxt = in_word.field_shift;
          rdsh_nxt  = '0;
          retry_nxt = '0;
          left_nxt  = limit_of((in_word.action == ACT_WRITE) ? wr_att_r : rd_att_r);
          idx_nxt   = '0;
          phase_nxt = PH_FRAME;
          push0     = start_w;
          push_cnt  = 2'd1;
        end
      end else if (in_word.action == ACT_RX_BYTE) begin
        case (phase_r)
          PH_FRAME: begin
            idx_nxt  = idx_inc;
            push_cnt = 2'd1;
            if (idx_inc < (writing ? WR_FRAME_LEN : RD_FRAME_LEN)) begin
              push0.send_byte = fbyte;
            end else begin
              phase_nxt = PH_POLL;
            end
          end
          PH_POLL: begin
            push_cnt = 2'd1;
            if (in_word.rx_byte == ACK_BYTE) begin
              if (writing) begin
                phase_nxt = PH_IDLE;
                wpend_nxt = 1'b0;
                push0     = fin_w;
              end else begin
                phase_nxt = PH_DATA;
                idx_nxt   = '0;
                rdsh_nxt  = '0;
              end
            end else if (in_word.rx_byte == TIMEOUT_BYTE) begin
              left_nxt  = left_dec;
              retry_nxt = retry_inc;
              if (left_dec == 5'd0) begin
                phase_nxt           = PH_IDLE;
                wpend_nxt           = 1'b0;
                push0               = fin_w;
                push0.status        = 1'b1;
                push0.attempts_used = retry_inc;
              end else begin
                idx_nxt   = '0;
                phase_nxt = PH_FRAME;
                push0     = rel_w;
                push_cnt  = 2'd2;
              end
            end
          end
          PH_DATA: begin
            rdsh_nxt = rx_sh;
            idx_nxt  = idx_inc;
            push_cnt = 2'd1;
            if (idx_inc >= DATA_BYTES) begin
              case (kind_r)
                KIND_EXTRACT: begin
                  phase_nxt       = PH_IDLE;
                  wpend_nxt       = 1'b0;
                  push0           = fin_w;
                  push0.read_data = (rx_sh & mask_r) >> shift_r;
                end
                KIND_MODIFY: begin
                  data_nxt  = (rx_sh & ~mask_r) + (data_r << shift_r);
                  wpend_nxt = 1'b1;
                  left_nxt  = limit_of(wr_att_r);
                  idx_nxt   = '0;
                  phase_nxt = PH_FRAME;
                  push0     = rel_w;
                  push_cnt  = 2'd2;
                end
                default: begin
                  phase_nxt       = PH_IDLE;
                  wpend_nxt       = 1'b0;
                  push0           = fin_w;
                  push0.read_data = rx_sh;
                end
              endcase
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= KIND_WRITE;
      wpend_r <= 1'b0;
      idx_r   <= '0;
      left_r  <= '0;
      retry_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      wpend_r <= wpend_nxt;
      idx_r   <= idx_nxt;
      left_r  <= left_nxt;
      retry_r <= retry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    data_r  <= data_nxt;
    mask_r  <= mask_nxt;
    shift_r <= shift_nxt;
    rdsh_r  <= rdsh_nxt;
  end

  sra_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push0      (push0),
    .push1      (push1),
    .space_ok   (space_ok),
    .head_valid (head_valid),
    .head_ready (out_word.ready),
    .head       (head)
  );

  assign out_word.valid         = head_valid;
  assign out_word.send_valid    = head.send_valid;
  assign out_word.send_byte     = head.send_byte;
  assign out_word.select_active = head.select_active;
  assign out_word.done_res      = head.done_res;
  assign out_word.status        = head.status;
  assign out_word.read_data     = head.read_data;
  assign out_word.attempts_used = head.attempts_used;
  assign out_word.last          = head.last;

endmodule

[tb/sra_check_pkg.sv]
// ----------------------------------------------------------------------------
// SPI register access checker
// Follows the master's framing, polling, retry and data capture state for
// every accepted request or link byte and checks each result word against it.
// ----------------------------------------------------------------------------
package sra_check_pkg;
  import sra_pkg::*;

  class link_scoreboard;
    logic [4:0]  wr_limit = WR_ATTEMPTS_RST;
    logic [4:0]  rd_limit = RD_ATTEMPTS_RST;
    phase_t      phase = PH_IDLE;
    kind_t       kind = KIND_WRITE;
    bit          write_pending;
    logic [3:0]  byte_idx;
    logic [4:0]  tries_left;
    logic [4:0]  retries;
    logic [31:0] addr_q;
    logic [31:0] data_q;
    logic [31:0] mask_q;
    logic [4:0]  shift_q;
    logic [31:0] rd_shift;
    res_t        due_words[$];
    int          mismatches;
    int          checked;
    int          requests;
    int          timeouts;
    int          failures;
    int          saturated;

    function void set_limit(reg_idx_t idx, logic [4:0] v);
      if (idx == REG_WRITE_ATTEMPTS) wr_limit = v;
      else rd_limit = v;
    endfunction

    function bit writing();
      return kind == KIND_WRITE || (kind == KIND_MODIFY && write_pending);
    endfunction

    function logic [3:0] frame_len();
      return writing() ? WR_FRAME_LEN : RD_FRAME_LEN;
    endfunction

    function logic [7:0] frame_byte(logic [3:0] idx);
      int i;
      i = idx;
      if (i == 0) return BYTE_SYNC;
      if (i == 1) return writing() ? WR_OPCODE : RD_OPCODE;
      if (i == 2) return writing() ? WR_LENGTH : RD_LENGTH;
      if (i <= 6) return 8'(addr_q >> (8 * (6 - i)));
      if (writing() && i <= 10) return 8'(data_q >> (8 * (10 - i)));
      return BYTE_SYNC;
    endfunction

    function void queue_res(bit sv, logic [7:0] b, bit sel, bit done, bit st,
                            logic [31:0] data, logic [4:0] used, bit last);
      res_t r;
      r.send_valid    = sv;
      r.send_byte     = b;
      r.select_active = sel;
      r.done_res      = done;
      r.status        = st;
      r.read_data     = data;
      r.attempts_used = used;
      r.last          = last;
      due_words.push_back(r);
    endfunction

    function void start_attempt();
      byte_idx = 0;
      phase = PH_FRAME;
      queue_res(1, BYTE_SYNC, 1, 0, 0, 0, 0, 1);
    endfunction

    function void release_select();
      queue_res(0, 0, 0, 0, 0, 0, 0, 0);
    endfunction

    function void finish(bit st, logic [31:0] data);
      phase = PH_IDLE;
      write_pending = 0;
      if (st) failures++;
      if (retries == RETRY_MAX) saturated++;
      queue_res(0, 0, 0, 1, st, data, retries, 1);
    endfunction

    function int note_word(logic [2:0] act, logic [31:0] a, logic [31:0] d,
                           logic [31:0] m, logic [4:0] s, logic [7:0] rx);
      logic [4:0] lim;
      if (act <= ACT_MODIFY) begin
        if (phase != PH_IDLE) return 0;
        kind = kind_t'(act[1:0]);
        write_pending = 0;
        addr_q = a;
        data_q = d;
        mask_q = m;
        shift_q = s;
        rd_shift = 0;
        retries = 0;
        lim = (act == ACT_WRITE) ? wr_limit : rd_limit;
        tries_left = (lim == 0) ? 5'd1 : lim;
        requests++;
        start_attempt();
        return 1;
      end
      if (act != ACT_RX_BYTE) return 0;
      case (phase)
        PH_FRAME: begin
          byte_idx = byte_idx + 1;
          if (byte_idx < frame_len()) begin
            queue_res(1, frame_byte(byte_idx), 1, 0, 0, 0, 0, 1);
          end else begin
            phase = PH_POLL;
            queue_res(1, POLL_BYTE, 1, 0, 0, 0, 0, 1);
          end
          return 1;
        end
        PH_POLL: begin
          if (rx == ACK_BYTE) begin
            if (writing()) begin
              finish(0, 0);
              return 1;
            end
            phase = PH_DATA;
            byte_idx = 0;
            rd_shift = 0;
            queue_res(1, POLL_BYTE, 1, 0, 0, 0, 0, 1);
            return 1;
          end
          if (rx == TIMEOUT_BYTE) begin
            tries_left = tries_left - 1;
            timeouts++;
            if (retries != RETRY_MAX) retries = retries + 1;
            if (tries_left == 0) begin
              finish(1, 0);
              return 1;
            end
            release_select();
            start_attempt();
            return 2;
          end
          queue_res(1, POLL_BYTE, 1, 0, 0, 0, 0, 1);
          return 1;
        end
        PH_DATA: begin
          rd_shift = {rd_shift[23:0], rx};
          byte_idx = byte_idx + 1;
          if (byte_idx < DATA_BYTES) begin
            queue_res(1, POLL_BYTE, 1, 0, 0, 0, 0, 1);
            return 1;
          end
          if (kind == KIND_EXTRACT) begin
            finish(0, (rd_shift & mask_q) >> shift_q);
            return 1;
          end
          if (kind == KIND_MODIFY) begin
            data_q = (rd_shift & ~mask_q) + (data_q << shift_q);
            write_pending = 1;
            tries_left = (wr_limit == 0) ? 5'd1 : wr_limit;
            release_select();
            start_attempt();
            return 2;
          end
          finish(0, rd_shift);
          return 1;
        end
        default: return 0;
      endcase
    endfunction

    function void check_field(string label, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (due_words.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing, actual %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = due_words.pop_front();
      checked++;
      check_field("send_valid", want.send_valid, got.send_valid);
      check_field("send_byte", want.send_byte, got.send_byte);
      check_field("select_active", want.select_active, got.select_active);
      check_field("done_res", want.done_res, got.done_res);
      check_field("status", want.status, got.status);
      check_field("read_data", want.read_data, got.read_data);
      check_field("attempts_used", want.attempts_used, got.attempts_used);
      check_field("last", want.last, got.last);
    endfunction
  endclass

endpackage

[tb/tb_spi_register_access_master.sv]
// ----------------------------------------------------------------------------
// SPI register access master testbench
// Plays the link slave: sends requests, then answers each frame byte, poll,
// timeout and data byte, with sender bursts, receiver stalls and a long
// result hold-off. Limits are reprogrammed between phases over APB and read
// back; every result word is checked against a cycle-free prediction.
// ----------------------------------------------------------------------------
module tb_spi_register_access_master;
  import sra_pkg::*;
  import sra_check_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sra_in_if  in_if();
  sra_out_if out_if();

  spi_register_access_master uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_word  (in_if),
    .out_word (out_if)
  );

  link_scoreboard tracker = new();

  int         burst_left;
  int         words_taken;
  int         settings;
  int         hold_offs;
  bit         hold_off_req;
  logic [4:0] cur_wr;
  logic [4:0] cur_rd;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("spi_register_access_master regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      tracker.check_word({out_if.send_valid, out_if.send_byte, out_if.select_active,
                          out_if.done_res, out_if.status, out_if.read_data,
                          out_if.attempts_used, out_if.last});
  end

  initial begin
    int         mode;
    int         span;
    logic [7:0] pat;
    bit         r;
    out_if.ready <= 1'b0;
    pat = 8'b1101_0110;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off_req = 0;
        hold_offs++;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 200);
      repeat (span) begin
        if (hold_off_req) break;
        case (mode)
          0: r = 1'b1;
          1: r = $urandom_range(0, 3) != 0;
          2: r = $urandom_range(0, 3) == 0;
          default: begin
            r = pat[0];
            pat = {pat[0], pat[7:1]};
          end
        endcase
        out_if.ready <= r;
        @(posedge clk);
      end
    end
  end

  task automatic put_word(logic [2:0] act, logic [31:0] a, logic [31:0] d,
                          logic [31:0] m, logic [4:0] s, logic [7:0] rx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.action      <= act;
    in_if.address     <= a;
    in_if.write_data  <= d;
    in_if.field_mask  <= m;
    in_if.field_shift <= s;
    in_if.rx_byte     <= rx;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (tracker.note_word(act, a, d, m, s, rx) > 0) words_taken++;
  endtask

  task automatic put_rx(logic [7:0] b);
    put_word(ACT_RX_BYTE, $urandom, $urandom, $urandom, 5'($urandom_range(0, 31)), b);
  endtask

  task automatic put_noise();
    logic [2:0] act;
    if ($urandom_range(0, 1) == 0) act = 3'($urandom_range(ACT_WRITE, ACT_MODIFY));
    else act = 3'(ACT_RX_BYTE) + 3'($urandom_range(1, 3));
    put_word(act, $urandom, $urandom, $urandom, 5'($urandom_range(0, 31)),
             8'($urandom_range(0, 255)));
  endtask

  task automatic run_request(action_t act, logic [31:0] a, logic [31:0] d,
                             logic [31:0] m, logic [4:0] s, int rd_to, int wr_to,
                             logic [31:0] reg_val, int noise_pct);
    int         to_left;
    bit         in_write;
    logic [7:0] b;
    put_word(act, a, d, m, s, 8'($urandom_range(0, 255)));
    in_write = (act == ACT_WRITE);
    to_left = in_write ? wr_to : rd_to;
    while (tracker.phase != PH_IDLE) begin
      if (!in_write && tracker.write_pending) begin
        in_write = 1;
        to_left = wr_to;
      end
      if ($urandom_range(1, 100) <= noise_pct) begin
        put_noise();
      end else begin
        case (tracker.phase)
          PH_FRAME: put_rx(8'($urandom_range(0, 255)));
          PH_POLL: begin
            if ($urandom_range(0, 3) == 0) begin
              do b = 8'($urandom_range(0, 255));
              while (b == ACK_BYTE || b == TIMEOUT_BYTE);
              put_rx(b);
            end else if (to_left > 0) begin
              to_left--;
              put_rx(TIMEOUT_BYTE);
            end else begin
              put_rx(ACK_BYTE);
            end
          end
          default: put_rx(8'(reg_val >> (8 * (3 - int'(tracker.byte_idx)))));
        endcase
      end
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk);
    while (tracker.due_words.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [4:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {27'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_limit(idx, v);
    @(posedge clk);
  endtask

  task automatic reg_check(reg_idx_t idx, logic [4:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata !== {27'd0, want}) begin
      $display("%0t: register %0d readback mismatch, expected %h, actual %h",
               $time, idx, {27'd0, want}, prdata);
      tracker.mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_limits(logic [4:0] w, logic [4:0] r);
    settle();
    reg_write(REG_WRITE_ATTEMPTS, w);
    reg_write(REG_READ_ATTEMPTS, r);
    reg_check(REG_WRITE_ATTEMPTS, w);
    reg_check(REG_READ_ATTEMPTS, r);
    cur_wr = w;
    cur_rd = r;
    settings++;
  endtask

  function automatic int pick_timeouts(logic [4:0] lim);
    int cap;
    int p;
    cap = (lim == 0) ? 1 : lim;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(0, cap + 1);
  endfunction

  function automatic logic [31:0] pick_mask();
    int w;
    int p;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        w = $urandom_range(1, 32);
        p = $urandom_range(0, 31);
        return ((w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1)) << p;
      end
      2: return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom & $urandom;
    endcase
  endfunction

  task automatic random_chunk(int count);
    int         target;
    logic [31:0] rv;
    target = words_taken + count;
    while (words_taken < target) begin
      if ($urandom_range(0, 99) < 8) begin
        if ($urandom_range(0, 1) == 0) put_rx(8'($urandom_range(0, 255)));
        else put_word(3'(ACT_RX_BYTE) + 3'($urandom_range(1, 3)), $urandom, $urandom,
                      $urandom, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
      end else begin
        rv = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
        run_request(action_t'($urandom_range(ACT_WRITE, ACT_MODIFY)), $urandom,
                    $urandom, pick_mask(), 5'($urandom_range(0, 31)),
                    pick_timeouts(cur_rd), pick_timeouts(cur_wr), rv, 5);
      end
    end
  endtask

  initial begin
    in_if.valid       <= 1'b0;
    in_if.action      <= ACT_RX_BYTE;
    in_if.address     <= '0;
    in_if.write_data  <= '0;
    in_if.field_mask  <= '0;
    in_if.field_shift <= '0;
    in_if.rx_byte     <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cur_wr = WR_ATTEMPTS_RST;
    cur_rd = RD_ATTEMPTS_RST;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    reg_check(REG_WRITE_ATTEMPTS, WR_ATTEMPTS_RST);
    reg_check(REG_READ_ATTEMPTS, RD_ATTEMPTS_RST);

    put_rx(8'hA5);
    put_word(3'(ACT_RX_BYTE) + 3'd1, '0, '0, '0, '0, '0);
    put_word(3'(ACT_RX_BYTE) + 3'd2, '1, '1, '1, '1, '1);
    put_word(3'(ACT_RX_BYTE) + 3'd3, '0, '0, '0, '0, '0);
    run_request(ACT_WRITE, 32'h0, 32'h0, 32'h0, 5'd0, 0, 0, 32'h0, 0);
    run_request(ACT_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, 5'd31, 0, 1, '0, 0);
    run_request(ACT_READ, 32'h0, 32'h0, 32'h0, 5'd0, 2, 0, 32'hFFFF_FFFF, 0);
    run_request(ACT_READ, 32'hFFFF_FFFF, '1, '1, 5'd31, 0, 0, 32'h0, 20);
    run_request(ACT_EXTRACT, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 5'd31, 0, 0,
                32'h8000_0000, 0);
    run_request(ACT_EXTRACT, 32'h8765_4321, 32'h0, 32'h0, 5'd0, 0, 0, 32'hFFFF_FFFF, 0);
    run_request(ACT_EXTRACT, 32'hA5A5_5A5A, 32'h0, 32'h0000_FF00, 5'd8, 1, 0,
                32'h0000_A5C3, 0);
    run_request(ACT_MODIFY, 32'hC0DE_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 0, 0,
                32'h1234_5678, 0);
    run_request(ACT_MODIFY, 32'h0000_0100, 32'h1, 32'h0, 5'd0, 1, 1, 32'hFFFF_FFFF, 0);
    run_request(ACT_WRITE, 32'h5555_AAAA, 32'hAAAA_5555, '0, 5'd0, 0, 5, '0, 0);

    apply_limits(5'd31, 5'd31);
    run_request(ACT_MODIFY, 32'h0F0F_F0F0, 32'h3, 32'h0000_00F0, 5'd4, 30, 4,
                32'hDEAD_BEEF, 0);
    hold_off_req = 1;
    random_chunk(40);

    apply_limits(5'd0, 5'd0);
    run_request(ACT_MODIFY, 32'h0000_0040, 32'h7, 32'h7, 5'd0, 1, 0, 32'h0, 0);
    run_request(ACT_WRITE, 32'h0000_0044, 32'h1, '0, 5'd0, 0, 1, '0, 0);
    run_request(ACT_READ, 32'h0000_0048, '0, '0, 5'd0, 0, 0, 32'h0BAD_F00D, 0);
    random_chunk(40);

    apply_limits(5'd1, 5'd2);
    random_chunk(40);

    apply_limits(5'($urandom_range(1, 31)), 5'($urandom_range(1, 31)));
    random_chunk(40);

    apply_limits(5'd31, 5'd1);
    random_chunk(40);

    settle();
    repeat (20) @(posedge clk);

    $display("covered %0d requests over %0d limit settings, %0d result words checked",
             tracker.requests, settings, tracker.checked);
    $display("%0d link timeouts, %0d requests out of attempts, %0d saturated counts,"
             , tracker.timeouts, tracker.failures, tracker.saturated,
             " %0d long result hold-offs", hold_offs);
    if (tracker.mismatches == 0 && tracker.due_words.size() == 0) begin
      $display("spi_register_access_master regression: pass");
    end else begin
      $display("spi_register_access_master regression: fail");
    end
    $finish;
  end

endmodule
